/* hdl/rqps_pkg.sv */
// Shared constants and helpers for the ready queue policy selector.
// Holds command, policy and status codes, default sizes and the priority refill map.
// No dependencies.
package rqps_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TIME_BITS_DEF   = 32;

    localparam int TIME_PORT_W = 32;
    localparam int PROC_W      = 6;
    localparam int REM_W       = 16;
    localparam int PRIO_W      = 3;
    localparam int OCC_W       = 5;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SELECT = 1'b1;

    localparam logic [1:0] POL_EARLIEST = 2'd0;
    localparam logic [1:0] POL_LATEST   = 2'd1;
    localparam logic [1:0] POL_SHORTEST = 2'd2;
    localparam logic [1:0] POL_PRIO     = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [PRIO_W-1:0] PRIO_MINUS_ONE = 3'b111;
    localparam logic [PRIO_W-1:0] PRIO_MAX       = 3'b011;

    // static priority minus one, clamped into the 3-bit signed range
    function automatic logic [PRIO_W-1:0] prio_refill(input logic [PRIO_W-1:0] stat);
        logic [PRIO_W-1:0] res;
        begin
            if (stat == '0)
            begin
                res = PRIO_MINUS_ONE;
            end
            else if (stat[PRIO_W-1])
            begin
                res = PRIO_MAX;
            end
            else
            begin
                res = stat - 1'b1;
            end
            return res;
        end
    endfunction

endpackage

/* hdl/rqps_ram.sv */
// Single write port, single registered read port queue entry memory.
// Used by the ready queue policy selector; no package dependencies.
module rqps_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

/* hdl/ready_queue_policy_selector.sv */
// Ready queue of process entries with policy based select and removal.
// Depends on rqps_pkg and rqps_ram.
//
//  channel   handshake              payload
//  input     in_valid / in_stall    cmd proc_id ready_time remaining_time static_prio dyn_prio
//  output    out_valid / out_stall  status sel_proc_id sel_ready_time sel_dyn_prio
//                                   prio_reset occupancy
//  config    cfg_valid / cfg_ready  policy
//
// An insert writes the entry straight into the entry memory. A select with N entries
// reads them all to find the best index B, then moves the entries above B down one place;
// the priority policy adds a check pass over all entries first, and a refill rewrites every
// entry from index 0. The single read port of the entry memory reads one entry a cycle.
// in_stall is high from acceptance until the result is handed to the output register.
// A finished result waits in the output register while out_stall is high.
// Reset empties the queue and sets the policy to earliest first.
module ready_queue_policy_selector #(
    parameter int QUEUE_DEPTH = rqps_pkg::QUEUE_DEPTH_DEF,
    parameter int TIME_BITS   = rqps_pkg::TIME_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               cmd,
    input  logic [rqps_pkg::PROC_W-1:0]        proc_id,
    input  logic [rqps_pkg::TIME_PORT_W-1:0]   ready_time,
    input  logic [rqps_pkg::REM_W-1:0]         remaining_time,
    input  logic [rqps_pkg::PRIO_W-1:0]        static_prio,
    input  logic signed [rqps_pkg::PRIO_W-1:0] dyn_prio,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         status,
    output logic [rqps_pkg::PROC_W-1:0]        sel_proc_id,
    output logic [rqps_pkg::TIME_PORT_W-1:0]   sel_ready_time,
    output logic signed [rqps_pkg::PRIO_W-1:0] sel_dyn_prio,
    output logic                               prio_reset,
    output logic [rqps_pkg::OCC_W-1:0]         occupancy,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [1:0]                         policy
);

    localparam int TW = (TIME_BITS < rqps_pkg::TIME_PORT_W) ? TIME_BITS
                                                            : rqps_pkg::TIME_PORT_W;
    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int DYN_LSB  = 0;
    localparam int ST_LSB   = DYN_LSB + rqps_pkg::PRIO_W;
    localparam int REM_LSB  = ST_LSB + rqps_pkg::PRIO_W;
    localparam int TIME_LSB = REM_LSB + rqps_pkg::REM_W;
    localparam int PROC_LSB = TIME_LSB + TW;
    localparam int EW       = PROC_LSB + rqps_pkg::PROC_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_SCAN  = 5'b00100,
        S_MOVE  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] iss_reg, iss_next;
    logic          dv_reg, dv_next;
    logic [IW-1:0] di_reg, di_next;
    logic          all_low_reg, all_low_next;
    logic          rst_flag_reg, rst_flag_next;
    logic          is_sel_reg, is_sel_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic [1:0]    policy_reg;

    logic [IW-1:0]                  best_idx_reg, best_idx_next;
    logic [rqps_pkg::PROC_W-1:0]    best_proc_reg, best_proc_next;
    logic [TW-1:0]                  best_time_reg, best_time_next;
    logic [rqps_pkg::REM_W-1:0]     best_rem_reg, best_rem_next;
    logic [rqps_pkg::PRIO_W-1:0]    best_dyn_reg, best_dyn_next;

    logic          out_valid_reg;
    logic [1:0]    status_reg;
    logic [rqps_pkg::PROC_W-1:0]      sel_proc_reg;
    logic [rqps_pkg::TIME_PORT_W-1:0] sel_time_reg;
    logic [rqps_pkg::PRIO_W-1:0]      sel_dyn_reg;
    logic          prio_reset_reg;
    logic [rqps_pkg::OCC_W-1:0]       occ_reg;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic [IW-1:0] rd_addr;
    logic [EW-1:0] rd_data;

    logic                        in_acc;
    logic                        out_load;
    logic [FW-1:0]               last_fill;
    logic                        issuing;
    logic                        is_last;
    logic                        better;
    logic                        take;
    logic [FW-1:0]               mv_src;
    logic [rqps_pkg::PROC_W-1:0] r_proc;
    logic [TW-1:0]               r_time;
    logic [rqps_pkg::REM_W-1:0]  r_rem;
    logic [rqps_pkg::PRIO_W-1:0] r_st;
    logic [rqps_pkg::PRIO_W-1:0] r_dyn;
    logic [rqps_pkg::PRIO_W-1:0] r_eff;

    rqps_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    assign r_proc = rd_data[PROC_LSB +: rqps_pkg::PROC_W];
    assign r_time = rd_data[TIME_LSB +: TW];
    assign r_rem  = rd_data[REM_LSB +: rqps_pkg::REM_W];
    assign r_st   = rd_data[ST_LSB +: rqps_pkg::PRIO_W];
    assign r_dyn  = rd_data[DYN_LSB +: rqps_pkg::PRIO_W];
    assign r_eff  = rst_flag_reg ? rqps_pkg::prio_refill(r_st) : r_dyn;

    assign last_fill = fill_reg - 1'b1;
    assign is_last   = dv_reg && (FW'(di_reg) == last_fill);
    assign mv_src    = (iss_reg < FW'(best_idx_reg)) ? iss_reg : FW'(iss_reg + 1'b1);
    assign rd_addr   = (state_reg == S_MOVE) ? mv_src[IW-1:0] : iss_reg[IW-1:0];

    always_comb
    begin
        case (state_reg)
            S_CHECK, S_SCAN: issuing = (iss_reg < fill_reg);
            S_MOVE:          issuing = (iss_reg < last_fill);
            default:         issuing = 1'b0;
        endcase
    end

    always_comb
    begin
        case (policy_reg)
            rqps_pkg::POL_EARLIEST: better = (r_time < best_time_reg);
            rqps_pkg::POL_LATEST:   better = (r_time >= best_time_reg);
            rqps_pkg::POL_SHORTEST: better = (r_rem < best_rem_reg);
            default:                better = ($signed(r_eff) > $signed(best_dyn_reg));
        endcase
    end

    assign take = (di_reg == '0) || better;

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        iss_next        = iss_reg;
        dv_next         = issuing;
        di_next         = iss_reg[IW-1:0];
        all_low_next    = all_low_reg;
        rst_flag_next   = rst_flag_reg;
        is_sel_next     = is_sel_reg;
        res_status_next = res_status_reg;
        best_idx_next   = best_idx_reg;
        best_proc_next  = best_proc_reg;
        best_time_next  = best_time_reg;
        best_rem_next   = best_rem_reg;
        best_dyn_next   = best_dyn_reg;
        wr_en           = 1'b0;
        wr_addr         = di_reg;
        wr_data         = {r_proc, r_time, r_rem, r_st, r_eff};

        if (issuing)
        begin
            iss_next = FW'(iss_reg + 1'b1);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_DONE;
                    iss_next   = '0;
                    if (cmd == rqps_pkg::CMD_INSERT)
                    begin
                        is_sel_next = 1'b0;
                        if (fill_reg >= FW'(QUEUE_DEPTH))
                        begin
                            res_status_next = rqps_pkg::ST_FULL;
                        end
                        else
                        begin
                            res_status_next = rqps_pkg::ST_OK;
                            wr_en     = 1'b1;
                            wr_addr   = fill_reg[IW-1:0];
                            wr_data   = {proc_id, ready_time[TW-1:0], remaining_time,
                                         static_prio, dyn_prio};
                            fill_next = FW'(fill_reg + 1'b1);
                        end
                    end
                    else
                    begin
                        is_sel_next   = 1'b1;
                        rst_flag_next = 1'b0;
                        all_low_next  = 1'b1;
                        if (fill_reg == '0)
                        begin
                            res_status_next = rqps_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            res_status_next = rqps_pkg::ST_OK;
                            state_next = (policy_reg == rqps_pkg::POL_PRIO) ? S_CHECK : S_SCAN;
                        end
                    end
                end
            end
            S_CHECK:
            begin
                if (dv_reg && !r_dyn[rqps_pkg::PRIO_W-1])
                begin
                    all_low_next = 1'b0;
                end
                if (is_last)
                begin
                    rst_flag_next = all_low_reg && r_dyn[rqps_pkg::PRIO_W-1];
                    iss_next      = '0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (dv_reg && take)
                begin
                    best_idx_next  = di_reg;
                    best_proc_next = r_proc;
                    best_time_next = r_time;
                    best_rem_next  = r_rem;
                    best_dyn_next  = r_eff;
                end
                if (is_last)
                begin
                    iss_next   = rst_flag_reg ? '0 : FW'(best_idx_next);
                    state_next = S_MOVE;
                end
            end
            S_MOVE:
            begin
                if (dv_reg)
                begin
                    wr_en = 1'b1;
                end
                if (!issuing && !dv_reg)
                begin
                    fill_next  = last_fill;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            iss_reg       <= '0;
            dv_reg        <= 1'b0;
            policy_reg    <= rqps_pkg::POL_EARLIEST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            iss_reg   <= iss_next;
            dv_reg    <= dv_next;
            if (cfg_valid && cfg_ready)
            begin
                policy_reg <= policy;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        di_reg         <= di_next;
        all_low_reg    <= all_low_next;
        rst_flag_reg   <= rst_flag_next;
        is_sel_reg     <= is_sel_next;
        res_status_reg <= res_status_next;
        best_idx_reg   <= best_idx_next;
        best_proc_reg  <= best_proc_next;
        best_time_reg  <= best_time_next;
        best_rem_reg   <= best_rem_next;
        best_dyn_reg   <= best_dyn_next;
        if (out_load)
        begin
            status_reg <= res_status_reg;
            occ_reg    <= rqps_pkg::OCC_W'(fill_reg);
            if (is_sel_reg && (res_status_reg == rqps_pkg::ST_OK))
            begin
                sel_proc_reg   <= best_proc_reg;
                sel_time_reg   <= rqps_pkg::TIME_PORT_W'(best_time_reg);
                sel_dyn_reg    <= best_dyn_reg;
                prio_reset_reg <= rst_flag_reg;
            end
            else
            begin
                sel_proc_reg   <= '0;
                sel_time_reg   <= '0;
                sel_dyn_reg    <= '0;
                prio_reset_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign sel_proc_id    = sel_proc_reg;
    assign sel_ready_time = sel_time_reg;
    assign sel_dyn_prio   = sel_dyn_reg;
    assign prio_reset     = prio_reset_reg;
    assign occupancy      = occ_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_DONE))
        else $error("result raised outside completion");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != rqps_pkg::ST_OK)) |->
            ((sel_proc_id == '0) && (prio_reset == 1'b0)))
        else $error("error request carries selection data");

    a_reset_prio_only: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_MOVE) && rst_flag_reg) |-> (policy_reg == rqps_pkg::POL_PRIO))
        else $error("priority refill outside priority policy");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for ready_queue_policy_selector: a queued driver, a monitor
// and a scheduling predictor compare every result under all four policies.
// Depends on rqps_pkg and the RTL of the block.
module tb_top;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 203;

    localparam logic [1:0] PHASE_POLICY [PHASES] = '{
        rqps_pkg::POL_EARLIEST, rqps_pkg::POL_PRIO, rqps_pkg::POL_LATEST,
        rqps_pkg::POL_SHORTEST, rqps_pkg::POL_PRIO, rqps_pkg::POL_EARLIEST,
        rqps_pkg::POL_SHORTEST, rqps_pkg::POL_LATEST};

    typedef struct {
        logic                               cmd;
        logic [rqps_pkg::PROC_W-1:0]        proc;
        logic [rqps_pkg::TIME_PORT_W-1:0]   rtime;
        logic [rqps_pkg::REM_W-1:0]         rem;
        logic [rqps_pkg::PRIO_W-1:0]        stat;
        logic signed [rqps_pkg::PRIO_W-1:0] dyn;
    } sched_req_t;

    typedef struct {
        logic [1:0]                         status;
        logic [rqps_pkg::PROC_W-1:0]        id;
        logic [rqps_pkg::TIME_PORT_W-1:0]   rtime;
        logic signed [rqps_pkg::PRIO_W-1:0] dyn;
        logic                               refill;
        logic [rqps_pkg::OCC_W-1:0]         occ;
    } sched_res_t;

    logic                               clk;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_stall;
    logic                               cmd = rqps_pkg::CMD_INSERT;
    logic [rqps_pkg::PROC_W-1:0]        proc_id = '0;
    logic [rqps_pkg::TIME_PORT_W-1:0]   ready_time = '0;
    logic [rqps_pkg::REM_W-1:0]         remaining_time = '0;
    logic [rqps_pkg::PRIO_W-1:0]        static_prio = '0;
    logic signed [rqps_pkg::PRIO_W-1:0] dyn_prio = '0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic [1:0]                         status;
    logic [rqps_pkg::PROC_W-1:0]        sel_proc_id;
    logic [rqps_pkg::TIME_PORT_W-1:0]   sel_ready_time;
    logic signed [rqps_pkg::PRIO_W-1:0] sel_dyn_prio;
    logic                               prio_reset;
    logic [rqps_pkg::OCC_W-1:0]         occupancy;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [1:0]                         policy = rqps_pkg::POL_EARLIEST;

    sched_req_t request_backlog [$];
    sched_res_t due_results [$];
    sched_req_t ready_list [$];
    logic [1:0] sched_policy = rqps_pkg::POL_EARLIEST;

    logic in_fire = 1'b0;
    int   quiet_cycles = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   mismatches = 0;
    int   results_checked = 0;
    int   n_insert = 0;
    int   n_select = 0;
    int   n_full = 0;
    int   n_empty = 0;
    int   n_refill = 0;

    ready_queue_policy_selector uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .proc_id        (proc_id),
        .ready_time     (ready_time),
        .remaining_time (remaining_time),
        .static_prio    (static_prio),
        .dyn_prio       (dyn_prio),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .sel_proc_id    (sel_proc_id),
        .sel_ready_time (sel_ready_time),
        .sel_dyn_prio   (sel_dyn_prio),
        .prio_reset     (prio_reset),
        .occupancy      (occupancy),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .policy         (policy)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic signed [rqps_pkg::PRIO_W-1:0] refill_prio(
        input logic [rqps_pkg::PRIO_W-1:0] stat);
        int v;
        v = int'(stat) - 1;
        if (v > 3)
        begin
            v = 3;
        end
        return rqps_pkg::PRIO_W'(v);
    endfunction

    function automatic sched_res_t run_scheduler(input sched_req_t req);
        sched_res_t res;
        int         best;
        bit         all_low;
        bit         wins;
        res = '{default: '0};
        if (req.cmd == rqps_pkg::CMD_INSERT)
        begin
            n_insert++;
            if (ready_list.size() >= rqps_pkg::QUEUE_DEPTH_DEF)
            begin
                res.status = rqps_pkg::ST_FULL;
                n_full++;
            end
            else
            begin
                ready_list.insert(ready_list.size(), req);
            end
        end
        else if (ready_list.size() == 0)
        begin
            n_select++;
            res.status = rqps_pkg::ST_EMPTY;
            n_empty++;
        end
        else
        begin
            n_select++;
            if (sched_policy == rqps_pkg::POL_PRIO)
            begin
                all_low = 1'b1;
                foreach (ready_list[i])
                begin
                    if (ready_list[i].dyn > -1)
                    begin
                        all_low = 1'b0;
                    end
                end
                if (all_low)
                begin
                    foreach (ready_list[i])
                    begin
                        ready_list[i].dyn = refill_prio(ready_list[i].stat);
                    end
                    res.refill = 1'b1;
                    n_refill++;
                end
            end
            best = 0;
            for (int i = 1; i < ready_list.size(); i++)
            begin
                case (sched_policy)
                    rqps_pkg::POL_EARLIEST:
                        wins = ready_list[i].rtime < ready_list[best].rtime;
                    rqps_pkg::POL_LATEST:
                        wins = ready_list[i].rtime >= ready_list[best].rtime;
                    rqps_pkg::POL_SHORTEST:
                        wins = ready_list[i].rem < ready_list[best].rem;
                    default:
                        wins = ready_list[i].dyn > ready_list[best].dyn;
                endcase
                if (wins)
                begin
                    best = i;
                end
            end
            res.id    = ready_list[best].proc;
            res.rtime = ready_list[best].rtime;
            res.dyn   = ready_list[best].dyn;
            ready_list.delete(best);
        end
        res.occ = rqps_pkg::OCC_W'(ready_list.size());
        return res;
    endfunction

    function automatic sched_req_t make_request(input bit pick);
        sched_req_t r;
        r.cmd  = pick ? rqps_pkg::CMD_SELECT : rqps_pkg::CMD_INSERT;
        r.proc = rqps_pkg::PROC_W'($urandom);
        case ($urandom_range(3))
            0:       r.rtime = rqps_pkg::TIME_PORT_W'($urandom_range(7));
            1:       r.rtime = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            default: r.rtime = rqps_pkg::TIME_PORT_W'($urandom);
        endcase
        r.rem  = $urandom_range(1) ? rqps_pkg::REM_W'($urandom_range(5))
                                   : rqps_pkg::REM_W'($urandom);
        r.stat = rqps_pkg::PRIO_W'($urandom);
        r.dyn  = $urandom_range(1) ? (3'b100 | rqps_pkg::PRIO_W'($urandom_range(3)))
                                   : rqps_pkg::PRIO_W'($urandom);
        return r;
    endfunction

    task automatic add_random(input int count);
        int left;
        int burst;
        int insert_pct;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(20, 1);
            if (burst > left)
            begin
                burst = left;
            end
            case ($urandom_range(2))
                0:       insert_pct = 85;
                1:       insert_pct = 50;
                default: insert_pct = 20;
            endcase
            repeat (burst)
            begin
                request_backlog.insert(request_backlog.size(),
                                       make_request($urandom_range(99) >= insert_pct));
            end
            left -= burst;
        end
    endtask

    task automatic drain();
        while (!(request_backlog.size() == 0 && !in_valid && due_results.size() == 0))
        begin
            @(posedge clk);
        end
    endtask

    task automatic note_mismatch(input string what, input sched_res_t want);
        if (mismatches < 10)
        begin
            $display("%0t %s: expected st=%0d id=%0d t=%h dyn=%0d rst=%0b occ=%0d",
                     $time, what, want.status, want.id, want.rtime, want.dyn,
                     want.refill, want.occ);
            $display("      got st=%0d id=%0d t=%h dyn=%0d rst=%0b occ=%0d",
                     status, sel_proc_id, sel_ready_time, sel_dyn_prio, prio_reset,
                     occupancy);
        end
        mismatches++;
    endtask

    // request driver: advance on acceptance, hold while stalled
    always @(negedge clk)
    begin
        sched_req_t nxt;
        if (rst_n)
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
            if (!in_valid || in_fire)
            begin
                if (request_backlog.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    nxt = request_backlog.pop_front();
                    in_valid       <= 1'b1;
                    cmd            <= nxt.cmd;
                    proc_id        <= nxt.proc;
                    ready_time     <= nxt.rtime;
                    remaining_time <= nxt.rem;
                    static_prio    <= nxt.stat;
                    dyn_prio       <= nxt.dyn;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        sched_req_t taken;
        sched_res_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_checked++;
                if (due_results.size() == 0)
                begin
                    note_mismatch("unexpected result", '{default: '0});
                end
                else
                begin
                    want = due_results.pop_front();
                    if (want.status !== status || want.id !== sel_proc_id ||
                        want.rtime !== sel_ready_time || want.dyn !== sel_dyn_prio ||
                        want.refill !== prio_reset || want.occ !== occupancy)
                    begin
                        note_mismatch("result mismatch", want);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                taken.cmd   = cmd;
                taken.proc  = proc_id;
                taken.rtime = ready_time;
                taken.rem   = remaining_time;
                taken.stat  = static_prio;
                taken.dyn   = dyn_prio;
                due_results.insert(due_results.size(), run_scheduler(taken));
            end
            if (cfg_valid && cfg_ready)
            begin
                sched_policy = policy;
            end
            in_fire <= in_valid && !in_stall;
            quiet_cycles <= ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                             (cfg_valid && cfg_ready)) ? 0 : quiet_cycles + 1;
        end
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
        end
        $display("timeout after %0d cycles without progress", QUIET_LIMIT);
        $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        sched_req_t r;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty select, fill to the brim with extreme fields, overflow, then drain some
        request_backlog.insert(request_backlog.size(), make_request(1'b1));
        for (int k = 0; k < rqps_pkg::QUEUE_DEPTH_DEF + 1; k++)
        begin
            r       = make_request(1'b0);
            r.proc  = (k == 15) ? 6'd63 : rqps_pkg::PROC_W'(k);
            r.rtime = (k == 1) ? 32'hFFFF_FFFF
                               : ((k % 4 == 0) ? 32'h0 : rqps_pkg::TIME_PORT_W'(k % 3));
            r.rem   = (k == 2) ? 16'hFFFF : rqps_pkg::REM_W'(k % 5);
            r.stat  = rqps_pkg::PRIO_W'(k);
            r.dyn   = rqps_pkg::PRIO_W'(k + 4);
            request_backlog.insert(request_backlog.size(), r);
        end
        repeat (7) request_backlog.insert(request_backlog.size(), make_request(1'b1));

        for (int p = 0; p < PHASES; p++)
        begin
            if (p != 0)
            begin
                @(negedge clk);
                cfg_valid <= 1'b1;
                policy    <= PHASE_POLICY[p];
                @(posedge clk);
                while (!cfg_ready)
                begin
                    @(posedge clk);
                end
                @(negedge clk);
                cfg_valid <= 1'b0;
                @(posedge clk);
            end
            case (p % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 61;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 61;
                end
                default:
                begin
                    idle_pct  = 17;
                    stall_pct = 17;
                end
            endcase
            add_random(PHASE_ITEMS / 2);
            drain();
            add_random(PHASE_ITEMS - PHASE_ITEMS / 2);
            drain();
            repeat (8) @(posedge clk);
        end

        repeat (60) @(posedge clk);
        $display("covered %0d inserts and %0d selects over %0d policy phases",
                 n_insert, n_select, PHASES);
        $display("%0d full inserts, %0d empty selects, %0d priority refills, %0d results checked",
                 n_full, n_empty, n_refill, results_checked);
        if (mismatches == 0 && due_results.size() == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("%0d mismatches, %0d results outstanding", mismatches, due_results.size());
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/rqps_pkg.sv
hdl/rqps_ram.sv
hdl/ready_queue_policy_selector.sv
dv/tb_top.sv
